### hdl/least_connection_slot_select_assert.svh
// Assertion macros shared by the slot selector RTL.
// Each use names a label, a property and a message; clk and arst_n are taken from
// the module that uses the macro.
`ifndef LEAST_CONNECTION_SLOT_SELECT_ASSERT_SVH
`define LEAST_CONNECTION_SLOT_SELECT_ASSERT_SVH

`ifndef SYNTHESIS

`define LCSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

`define LCSS_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`else

`define LCSS_ASSERT(lbl, prop, msg)

`define LCSS_NEVER(lbl, expr, msg)

`endif

`endif

### hdl/lcss_pkg.sv
`timescale 1ns / 1ps

package lcss_pkg;

	localparam int SLOT_W  = 10;
	localparam int COUNT_W = 32;
	localparam int CFG_W   = 11;

	// Reach of the slot field; no slot at or above it can be written or chosen.
	localparam int SLOT_SPAN = 1 << SLOT_W;

	localparam int MAX_SLOTS_DEF = 1024;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SELECT = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] count;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  chosen_slot;
		logic [COUNT_W-1:0] least_count;
	} rsp_t;

	// Scan token moving down the row of cells.
	typedef struct packed {
		logic               valid;
		logic               first;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] count;
	} tok_t;

endpackage

### hdl/least_connection_slot_select.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload                       Handshake
// req       in         mode, slot, count             req_valid / req_stall
// rsp       out        chosen_slot, least_count      rsp_valid / rsp_stall
// cfg       in         active_slots (11 bits)        cfg_we
//
// A write request gives no response; the slot count is registered at the edge that accepts it.
// A select request sends a token down the row of NCELL cells (NCELL = min(MAX_SLOTS, 1024)),
// one cell per cycle, and the response is registered from the token leaving the last cell.
// Reset clears every slot count and active_slots to zero at once; no clearing pass.
// req_stall is high while a scan is in flight and while a response waits on rsp_stall.

`include "least_connection_slot_select_assert.svh"

module least_connection_slot_select #(
	parameter int MAX_SLOTS = lcss_pkg::MAX_SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  lcss_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output lcss_pkg::rsp_t             rsp,
	input  logic                       cfg_we,
	input  logic [lcss_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int NCELL = (MAX_SLOTS < lcss_pkg::SLOT_SPAN) ? MAX_SLOTS : lcss_pkg::SLOT_SPAN;

	logic [lcss_pkg::CFG_W-1:0] active_slots_q;
	logic                       busy_q;
	logic                       rsp_valid_q;
	lcss_pkg::rsp_t             rsp_q;
	logic                       accept;
	logic                       wr_en;
	lcss_pkg::tok_t             tok [NCELL+1];
	logic [NCELL-1:0]           tok_v;

	assign req_stall = busy_q || rsp_valid_q;
	assign accept    = req_valid && !req_stall;
	assign wr_en     = accept && (req.mode == lcss_pkg::MODE_WRITE);

	assign tok[0] = '{
		valid: accept && (req.mode == lcss_pkg::MODE_SELECT),
		first: 1'b1,
		slot:  '0,
		count: '0
	};

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		lcss_cell #(
			.IDX(i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.wr_en       (wr_en),
			.wr_slot     (req.slot),
			.wr_count    (req.count),
			.active_slots(active_slots_q),
			.tok_in      (tok[i]),
			.tok_out     (tok[i+1])
		);
		assign tok_v[i] = tok[i+1].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_slots_q <= '0;
		end else if (cfg_we) begin
			active_slots_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (tok[0].valid) begin
				busy_q <= 1'b1;
			end else if (tok[NCELL].valid) begin
				busy_q <= 1'b0;
			end
			if (tok[NCELL].valid) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok[NCELL].valid) begin
			rsp_q.chosen_slot <= tok[NCELL].slot;
			rsp_q.least_count <= tok[NCELL].count;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The scan token is alone in the row, and it never lands on a waiting response.
	`LCSS_ASSERT(a_one_token, $countones(tok_v) <= 1, "more than one scan token in flight")
	`LCSS_NEVER(a_no_overwrite, tok[NCELL].valid && rsp_valid_q, "scan result overwrote response")
	`LCSS_ASSERT(a_busy_end, $fell(busy_q) |-> $past(tok[NCELL].valid), "busy ended without result")
	`LCSS_ASSERT(a_rsp_start, $rose(rsp_valid_q) |-> $fell(busy_q), "response rose outside scan end")
	`LCSS_NEVER(a_token_idle, (|tok_v) && !busy_q, "scan token in flight while idle")

endmodule

### hdl/lcss_cell.sv
`timescale 1ns / 1ps

module lcss_cell #(
	parameter int IDX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [lcss_pkg::SLOT_W-1:0] wr_slot,
	input  logic [lcss_pkg::COUNT_W-1:0] wr_count,
	input  logic [lcss_pkg::CFG_W-1:0]  active_slots,
	input  lcss_pkg::tok_t              tok_in,
	output lcss_pkg::tok_t              tok_out
);

	localparam logic [lcss_pkg::SLOT_W-1:0] ID     = lcss_pkg::SLOT_W'(IDX);
	localparam logic [lcss_pkg::CFG_W-1:0]  ID_EXT = lcss_pkg::CFG_W'(IDX);

	logic [lcss_pkg::COUNT_W-1:0] count_q;
	lcss_pkg::tok_t               tok_q;
	logic                         active;
	logic                         take;

	assign active = ID_EXT < active_slots;
	// The first cell seeds the running minimum with its own count, active or not.
	assign take   = tok_in.first || (active && (count_q < tok_in.count));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (wr_en && (wr_slot == ID)) begin
			count_q <= wr_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			if (tok_in.valid) begin
				tok_q.first <= 1'b0;
				if (take) begin
					tok_q.slot  <= ID;
					tok_q.count <= count_q;
				end else begin
					tok_q.slot  <= tok_in.slot;
					tok_q.count <= tok_in.count;
				end
			end
		end
	end

	assign tok_out = tok_q;

endmodule

### verif/slot_select_checker.sv
`timescale 1ns / 1ps

module slot_select_checker #(
	parameter int MAX_SLOTS = lcss_pkg::MAX_SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_stall,
	input  lcss_pkg::req_t             req,
	input  logic                       rsp_valid,
	input  logic                       rsp_stall,
	input  lcss_pkg::rsp_t             rsp,
	input  logic                       cfg_we,
	input  logic [lcss_pkg::CFG_W-1:0] cfg_wdata,
	output int                         fail_count,
	output int                         pending
);

	logic [lcss_pkg::COUNT_W-1:0] slot_counts [MAX_SLOTS];
	logic [lcss_pkg::CFG_W-1:0]   active_slots;
	lcss_pkg::rsp_t               expected_picks [$];
	int                           picks_taken;
	int                           picks_seen;
	int                           fails;

	assign pending    = picks_taken - picks_seen;
	assign fail_count = fails;

	// Lowest count among the active slots; the running minimum starts at slot 0,
	// so a tie keeps the lower slot and an empty scan leaves slot 0 in place.
	function automatic lcss_pkg::rsp_t least_loaded();
		int unsigned    span;
		lcss_pkg::rsp_t best;
		span = 32'(active_slots);
		if (span > MAX_SLOTS)
			span = MAX_SLOTS;
		if (span > lcss_pkg::SLOT_SPAN)
			span = lcss_pkg::SLOT_SPAN;
		best.chosen_slot = '0;
		best.least_count = slot_counts[0];
		for (int unsigned i = 0; i < span; i++) begin
			if (slot_counts[i] < best.least_count) begin
				best.least_count = slot_counts[i];
				best.chosen_slot = i[lcss_pkg::SLOT_W-1:0];
			end
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		lcss_pkg::rsp_t want;
		int             errs;
		if (!arst_n) begin
			for (int i = 0; i < MAX_SLOTS; i++)
				slot_counts[i] = '0;
			active_slots = '0;
			expected_picks.delete();
			picks_taken <= 0;
			picks_seen  <= 0;
			fails       <= 0;
		end else begin
			errs = 0;
			if (cfg_we)
				active_slots = cfg_wdata;
			if (req_valid && !req_stall) begin
				if (req.mode == lcss_pkg::MODE_SELECT) begin
					expected_picks.push_back(least_loaded());
					picks_taken <= picks_taken + 1;
				end else if (req.slot < MAX_SLOTS) begin
					slot_counts[req.slot] = req.count;
				end
			end
			if (rsp_valid && !rsp_stall) begin
				picks_seen <= picks_seen + 1;
				if (expected_picks.size() == 0) begin
					$error("response with no select waiting: chosen_slot %0d least_count %0d",
						rsp.chosen_slot, rsp.least_count);
					errs++;
				end else begin
					want = expected_picks.pop_front();
					if (rsp.chosen_slot !== want.chosen_slot) begin
						$error("chosen_slot: expected %0d, actual %0d",
							want.chosen_slot, rsp.chosen_slot);
						errs++;
					end
					if (rsp.least_count !== want.least_count) begin
						$error("least_count: expected %0d, actual %0d",
							want.least_count, rsp.least_count);
						errs++;
					end
				end
			end
			fails <= fails + errs;
		end
	end

endmodule

### verif/tb_least_connection_slot_select.sv
`timescale 1ns / 1ps

module tb_least_connection_slot_select;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int HOLD_CYCLES = 3000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 47;
	// A stray response could still show up one full scan after the last one.
	localparam int DRAIN_WAIT  = 1100;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       req_valid;
	logic                       req_stall;
	lcss_pkg::req_t             req;
	logic                       rsp_valid;
	logic                       rsp_stall;
	lcss_pkg::rsp_t             rsp;
	logic                       cfg_we;
	logic [lcss_pkg::CFG_W-1:0] cfg_wdata;
	int                         fail_count;
	int                         pending;

	int                active_now = 0;
	bit                calm = 1'b0;
	int                hold_asked = 0;
	int                hold_done = 0;
	int                cycles = 0;
	int                plan [PHASES];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	least_connection_slot_select dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	slot_select_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic lcss_pkg::req_t mk(input logic m,
		input logic [lcss_pkg::SLOT_W-1:0] s, input logic [lcss_pkg::COUNT_W-1:0] c);
		lcss_pkg::req_t r;
		r.mode  = m;
		r.slot  = s;
		r.count = c;
		return r;
	endfunction

	// Offers one request, after a random gap unless calm is set, and returns at the edge that takes it.
	task automatic offer(input lcss_pkg::req_t r);
		int gap;
		int pick;
		gap = 0;
		if (!calm) begin
			pick = $urandom_range(9);
			if (pick >= 6 && pick <= 8)
				gap = $urandom_range(3, 1);
			else if (pick == 9)
				gap = $urandom_range(40, 10);
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Waits until every select has been answered and the last write has landed.
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_active(input int v);
		cfg_we     <= 1'b1;
		cfg_wdata  <= v[lcss_pkg::CFG_W-1:0];
		active_now = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Response side: random stall runs, occasional long ready stretches, and a
	// long hold-off whenever the stimulus asks for one.
	initial begin : rsp_side
		int pick;
		int run;
		logic stall_val;
		rsp_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_done != hold_asked) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = hold_done + 1;
			end else begin
				pick = $urandom_range(9);
				if (pick < 5) begin
					stall_val = 1'b0;
					run = $urandom_range(8, 1);
				end else if (pick < 8) begin
					stall_val = 1'b1;
					run = $urandom_range(4, 1);
				end else if (pick == 8) begin
					stall_val = 1'b1;
					run = $urandom_range(60, 20);
				end else begin
					stall_val = 1'b0;
					run = $urandom_range(1500, 100);
				end
				rsp_stall <= stall_val;
				repeat (run) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int                           span;
		int                           pick;
		logic                         m;
		logic [lcss_pkg::SLOT_W-1:0]  s;
		logic [lcss_pkg::COUNT_W-1:0] c;

		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight out of reset no slot is active, so slot 0 comes back.
		offer(mk(lcss_pkg::MODE_SELECT, 10'h3FF, 32'hFFFF_FFFF));
		offer(mk(lcss_pkg::MODE_WRITE, 10'd0, 32'hFFFF_FFFF));
		offer(mk(lcss_pkg::MODE_SELECT, 10'd0, 32'd0));
		settle();
		set_active(1);
		offer(mk(lcss_pkg::MODE_SELECT, 10'h2AA, 32'h5555_5555));
		settle();
		set_active(2);
		offer(mk(lcss_pkg::MODE_SELECT, 10'd0, 32'd0));
		// Equal counts must keep the lower slot.
		offer(mk(lcss_pkg::MODE_WRITE, 10'd1, 32'hFFFF_FFFF));
		offer(mk(lcss_pkg::MODE_SELECT, 10'd0, 32'd0));
		offer(mk(lcss_pkg::MODE_WRITE, 10'd1, 32'hFFFF_FFFE));
		offer(mk(lcss_pkg::MODE_SELECT, 10'h155, 32'hAAAA_AAAA));
		settle();
		set_active(1024);
		offer(mk(lcss_pkg::MODE_WRITE, 10'h3FF, 32'h5555_5555));
		offer(mk(lcss_pkg::MODE_WRITE, 10'h2AA, 32'hAAAA_AAAA));
		offer(mk(lcss_pkg::MODE_WRITE, 10'h155, 32'd0));
		offer(mk(lcss_pkg::MODE_SELECT, 10'd0, 32'd0));
		offer(mk(lcss_pkg::MODE_WRITE, 10'd0, 32'd0));
		offer(mk(lcss_pkg::MODE_SELECT, 10'd0, 32'd0));
		settle();
		// Beyond the slot field the scan length saturates.
		set_active(2047);
		offer(mk(lcss_pkg::MODE_WRITE, 10'd0, 32'd7));
		offer(mk(lcss_pkg::MODE_SELECT, 10'h3FF, 32'hFFFF_FFFF));
		settle();

		plan = '{3, 1, 0, 1024, 2, 2047, 16, 0, 1023, 0, 200, 1};
		plan[7] = $urandom_range(63, 4);
		plan[9] = $urandom_range(2046, 1025);

		for (int ph = 0; ph < PHASES; ph++) begin
			set_active(plan[ph]);
			span = (active_now > lcss_pkg::SLOT_SPAN) ? lcss_pkg::SLOT_SPAN : active_now;
			calm = (ph % 4 == 1);
			if (ph == 4)
				hold_asked++;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				m = ($urandom_range(3) == 0) ? lcss_pkg::MODE_SELECT : lcss_pkg::MODE_WRITE;
				if (span > 0 && $urandom_range(4) != 0)
					s = lcss_pkg::SLOT_W'($urandom_range(span - 1));
				else
					s = lcss_pkg::SLOT_W'($urandom_range(lcss_pkg::SLOT_SPAN - 1));
				pick = $urandom_range(7);
				if (pick == 0)
					c = '0;
				else if (pick == 1)
					c = '1;
				else if (pick <= 3)
					c = $urandom_range(15);
				else if (pick <= 5)
					c = $urandom_range(1000);
				else
					c = $urandom();
				offer(mk(m, s, c));
			end
			settle();
		end
		calm = 1'b0;

		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/lcss_pkg.sv
hdl/lcss_cell.sv
hdl/least_connection_slot_select.sv
verif/slot_select_checker.sv
verif/tb_least_connection_slot_select.sv
